>>> src/cdm_pkg.sv
// Package for the concentric disc mapping block.
// Holds the work-fraction constant, inverse CORDIC gain and arctangent table.
// No dependencies.
package cdm_pkg;

    localparam int WORK_FRAC = 30;
    localparam int WORK_W = 34;
    localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

    typedef enum logic [1:0] {
        QUAD_ZERO  = 2'd0,
        QUAD_ONE   = 2'd1,
        QUAD_TWO   = 2'd2,
        QUAD_THREE = 2'd3
    } quad_t;

    function automatic logic [30:0] atan_units(input logic [4:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:  v = 31'd1073741824;
            5'd1:  v = 31'd633866812;
            5'd2:  v = 31'd334917814;
            5'd3:  v = 31'd170009512;
            5'd4:  v = 31'd85334662;
            5'd5:  v = 31'd42708930;
            5'd6:  v = 31'd21359676;
            5'd7:  v = 31'd10680490;
            5'd8:  v = 31'd5340326;
            5'd9:  v = 31'd2670174;
            5'd10: v = 31'd1335088;
            5'd11: v = 31'd667544;
            5'd12: v = 31'd333772;
            5'd13: v = 31'd166886;
            5'd14: v = 31'd83443;
            5'd15: v = 31'd41722;
            5'd16: v = 31'd20861;
            5'd17: v = 31'd10430;
            5'd18: v = 31'd5215;
            5'd19: v = 31'd2608;
            5'd20: v = 31'd1304;
            5'd21: v = 31'd652;
            5'd22: v = 31'd326;
            5'd23: v = 31'd163;
            5'd24: v = 31'd81;
            5'd25: v = 31'd41;
            5'd26: v = 31'd20;
            5'd27: v = 31'd10;
            5'd28: v = 31'd5;
            5'd29: v = 31'd3;
            5'd30: v = 31'd1;
            default: v = 31'd1;
        endcase
        return v;
    endfunction

endpackage

>>> src/concentric_disc_mapping_top.sv
// Concentric (square-to-disc) mapping, pipelined.
// Channels: s_valid/s_ready with s_u_first, s_u_second (unsigned Q0.INPUT_BITS);
// m_valid/m_ready with m_disc_x, m_disc_y (signed Q1.(OUTPUT_BITS-1)).
// Pipeline: 1 setup stage, 31 restoring-divider stages (one quotient bit each),
// 1 prescale-multiply stage, CORDIC_STEPS rotation stages, 1 output stage.
// CORDIC_STEPS over 32 acts as 32. One item per cycle unless the output stalls.
// The whole pipe advances together: when m_valid is high and m_ready low the
// pipe holds, and s_ready falls only then, so an item enters every cycle
// while the receiver takes results. A stall loses and repeats nothing.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload
// registers are not reset. The exact origin gives zero outputs; +1.0
// saturates to the largest positive code.
// Depends on cdm_pkg.
module concentric_disc_mapping_top
    import cdm_pkg::*;
#(
    parameter int INPUT_BITS = 16,
    parameter int OUTPUT_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [INPUT_BITS-1:0]         s_u_first,
    input  logic [INPUT_BITS-1:0]         s_u_second,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUTPUT_BITS-1:0] m_disc_x,
    output logic signed [OUTPUT_BITS-1:0] m_disc_y
);

    localparam int SW = INPUT_BITS + 2;          // signed offset width
    localparam int RW = INPUT_BITS + 1;          // magnitude width
    localparam int QB = WORK_FRAC + 1;           // quotient bits (ratio <= 2^30)
    localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int XW = WORK_W + 4;              // CORDIC datapath width
    localparam int ZW = 33;
    localparam int RW30 = RW + WORK_FRAC;

    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 0: offsets, region select
    logic               v0_reg;
    logic [RW-1:0]      r0_reg, n0_reg;
    logic               neg0_reg, zero0_reg;
    quad_t              q0_reg;

    logic signed [SW-1:0] sx, sy, r_s, num_s;
    quad_t                q_c;
    always_comb begin
        sx = $signed({1'b0, s_u_first, 1'b0}) - $signed({2'b01, {INPUT_BITS{1'b0}}});
        sy = $signed({1'b0, s_u_second, 1'b0}) - $signed({2'b01, {INPUT_BITS{1'b0}}});
        if (sx >= -sy) begin
            if (sx > sy) begin
                r_s = sx; num_s = sy; q_c = QUAD_ZERO;
            end else begin
                r_s = sy; num_s = -sx; q_c = QUAD_ONE;
            end
        end else begin
            if (sx <= sy) begin
                r_s = -sx; num_s = -sy; q_c = QUAD_TWO;
            end else begin
                r_s = -sy; num_s = sx; q_c = QUAD_THREE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
        end
        if (adv) begin
            r0_reg    <= r_s[RW-1:0];
            n0_reg    <= num_s[SW-1] ? RW'(-num_s) : num_s[RW-1:0];
            neg0_reg  <= num_s[SW-1];
            zero0_reg <= (r_s <= 0);
            q0_reg    <= q_c;
        end
    end

    // divider stages: quotient bit k = QB-1-j at stage j
    logic            dv_reg   [QB];
    logic [RW-1:0]   dr_reg   [QB];
    logic [RW30-1:0] drem_reg [QB];
    logic [QB-1:0]   dq_reg   [QB];
    logic            dneg_reg [QB];
    logic            dzero_reg[QB];
    quad_t           dquad_reg[QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic            pv, pneg, pzero;
        logic [RW-1:0]   pr;
        logic [RW30-1:0] prem;
        logic [QB-1:0]   pq;
        quad_t           pquad;
        logic [RW30:0]   trial;
        if (j == 0) begin : g_first
            assign pv = v0_reg; assign pr = r0_reg; assign pneg = neg0_reg;
            assign pzero = zero0_reg; assign pquad = q0_reg;
            assign prem = {n0_reg, {WORK_FRAC{1'b0}}};
            assign pq = '0;
        end else begin : g_rest
            assign pv = dv_reg[j-1]; assign pr = dr_reg[j-1]; assign pneg = dneg_reg[j-1];
            assign pzero = dzero_reg[j-1]; assign pquad = dquad_reg[j-1];
            assign prem = drem_reg[j-1]; assign pq = dq_reg[j-1];
        end
        assign trial = {1'b0, prem} - ({{(WORK_FRAC+1){1'b0}}, pr} << (QB - 1 - j));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_reg[j] <= pv;
            end
            if (adv) begin
                dr_reg[j] <= pr; dneg_reg[j] <= pneg;
                dzero_reg[j] <= pzero; dquad_reg[j] <= pquad;
                if (!trial[RW30]) begin
                    drem_reg[j] <= trial[RW30-1:0];
                    dq_reg[j]   <= pq | (QB'(1) << (QB - 1 - j));
                end else begin
                    drem_reg[j] <= prem;
                    dq_reg[j]   <= pq;
                end
            end
        end
    end

    // prescale stage
    logic                 pv_reg, pzero_reg;
    quad_t                pquad_reg;
    logic signed [XW-1:0] px_reg;
    logic signed [ZW-1:0] pz_reg;

    logic [RW-1:0]  rlast;
    logic [33:0]    rw30;
    logic [64:0]    prod;
    assign rlast = dr_reg[QB-1];
    always_comb begin
        if (INPUT_BITS <= WORK_FRAC)
            rw30 = 34'({{(64-RW){1'b0}}, rlast} << (WORK_FRAC - INPUT_BITS));
        else
            rw30 = 34'({{(64-RW){1'b0}}, rlast} >> (INPUT_BITS - WORK_FRAC));
        prod = {31'd0, rw30} * {34'd0, INV_GAIN_Q31} + (65'd1 << 30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (adv) begin
            pv_reg <= dv_reg[QB-1];
        end
        if (adv) begin
            pzero_reg <= dzero_reg[QB-1];
            pquad_reg <= dquad_reg[QB-1];
            px_reg    <= $signed(XW'(prod[64:31]));
            pz_reg    <= dneg_reg[QB-1] ? -$signed({2'b00, dq_reg[QB-1]})
                                        :  $signed({2'b00, dq_reg[QB-1]});
        end
    end

    // CORDIC stages
    logic                 cv_reg   [NS+1];
    logic                 czero_reg[NS+1];
    quad_t                cquad_reg[NS+1];
    logic signed [XW-1:0] cx_reg   [NS+1];
    logic signed [XW-1:0] cy_reg   [NS+1];
    logic signed [ZW-1:0] cz_reg   [NS+1];

    assign cv_reg[0] = pv_reg;
    assign czero_reg[0] = pzero_reg;
    assign cquad_reg[0] = pquad_reg;
    assign cx_reg[0] = px_reg;
    assign cy_reg[0] = '0;
    assign cz_reg[0] = pz_reg;

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic signed [XW-1:0] dx, dy;
        logic signed [ZW-1:0] at;
        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        assign at = $signed({2'b00, atan_units(5'(i))});
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                cv_reg[i+1] <= cv_reg[i];
            end
            if (adv) begin
                czero_reg[i+1] <= czero_reg[i];
                cquad_reg[i+1] <= cquad_reg[i];
                if (!cz_reg[i][ZW-1]) begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - at;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + at;
                end
            end
        end
    end

    // quarter-turn, round, saturate
    logic signed [XW-1:0] fx, fy, ex, ey;
    always_comb begin
        ex = cx_reg[NS];
        ey = cy_reg[NS];
        unique case (cquad_reg[NS])
            QUAD_ONE:   begin fx = -ey; fy = ex;  end
            QUAD_TWO:   begin fx = -ex; fy = -ey; end
            QUAD_THREE: begin fx = ey;  fy = -ex; end
            default:    begin fx = ex;  fy = ey;  end
        endcase
    end

    function automatic logic [OUTPUT_BITS-1:0] to_out(input logic signed [XW-1:0] v);
        logic signed [XW+33:0] w, r;
        logic signed [XW+33:0] hi, lo;
        hi = (XW+34)'((64'd1 << (OUTPUT_BITS - 1)) - 64'd1);
        lo = -hi - 1;
        w = (XW+34)'(v);
        if (OUTPUT_BITS - 1 <= WORK_FRAC) begin
            if (OUTPUT_BITS - 1 == WORK_FRAC)
                r = w;
            else
                r = (w + ((XW+34)'(1) <<< (WORK_FRAC - OUTPUT_BITS)))
                    >>> (WORK_FRAC + 1 - OUTPUT_BITS);
        end else begin
            r = w <<< (OUTPUT_BITS - 1 - WORK_FRAC);
        end
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r[OUTPUT_BITS-1:0];
    endfunction

    logic                   ov_reg;
    logic [OUTPUT_BITS-1:0] ox_reg, oy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= cv_reg[NS];
        end
        if (adv) begin
            ox_reg <= czero_reg[NS] ? '0 : to_out(fx);
            oy_reg <= czero_reg[NS] ? '0 : to_out(fy);
        end
    end

    assign m_valid  = ov_reg;
    assign m_disc_x = $signed(ox_reg);
    assign m_disc_y = $signed(oy_reg);

endmodule

>>> tb/sv/testbench.sv
// Testbench for concentric_disc_mapping_top: drives uniform value pairs and
// checks disc coordinates against a fixed-point square-to-disc predictor.
// Depends on cdm_pkg (quadrant type) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import cdm_pkg::*;

    localparam int IN_W = 16;
    localparam int OUT_W = 16;
    localparam int STEPS = 16;
    localparam int LATENCY = 34 + STEPS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1350;
    localparam longint GAIN_INV = 64'd1304065748;

    typedef struct packed {
        logic [IN_W-1:0] u_first;
        logic [IN_W-1:0] u_second;
    } pair_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [IN_W-1:0] s_u_first = '0;
    logic [IN_W-1:0] s_u_second = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_disc_x;
    logic signed [OUT_W-1:0] m_disc_y;

    pair_t pending_pairs[$];
    point_t expected_points[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int idle_cycles = 0;
    int hold_count = 0;
    bit stimulus_done = 0;
    bit quiet_span = 0;
    bit hold_done = 0;

    concentric_disc_mapping_top #(
        .INPUT_BITS(IN_W),
        .OUTPUT_BITS(OUT_W),
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_u_first(s_u_first), .s_u_second(s_u_second),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_disc_x(m_disc_x), .m_disc_y(m_disc_y)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint atan_step(int i);
        longint tbl[32] = '{
            1073741824, 633866812, 334917814, 170009512, 85334662, 42708930,
            21359676, 10680490, 5340326, 2670174, 1335088, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81, 41, 20, 10, 5, 3, 1, 1};
        return tbl[i];
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(longint v);
        longint r;
        longint hi;
        hi = (64'sd1 <<< (OUT_W - 1)) - 1;
        r = (v + (64'sd1 <<< (30 - OUT_W))) >>> (31 - OUT_W);
        if (r > hi) r = hi;
        if (r < -hi - 1) r = -hi - 1;
        return r[OUT_W-1:0];
    endfunction

    function automatic point_t map_to_disc(pair_t p);
        point_t res;
        longint sx, sy, r, num, x, y, z, t, dx, dy;
        longint unsigned mag, rw;
        quad_t quad;
        sx = 2 * longint'(p.u_first) - (64'sd1 <<< IN_W);
        sy = 2 * longint'(p.u_second) - (64'sd1 <<< IN_W);
        res = '0;
        if (sx == 0 && sy == 0) return res;
        if (sx >= -sy) begin
            if (sx > sy) begin r = sx; num = sy; quad = QUAD_ZERO; end
            else begin r = sy; num = -sx; quad = QUAD_ONE; end
        end else begin
            if (sx <= sy) begin r = -sx; num = -sy; quad = QUAD_TWO; end
            else begin r = -sy; num = sx; quad = QUAD_THREE; end
        end
        if (r <= 0) return res;
        mag = (num < 0) ? -num : num;
        mag = (mag << 30) / longint'(r);
        z = (num < 0) ? -longint'(mag) : longint'(mag);
        rw = longint'(r) << (30 - IN_W);
        x = longint'((rw * GAIN_INV + (64'd1 << 30)) >> 31);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        case (quad)
            QUAD_ONE: begin t = x; x = -y; y = t; end
            QUAD_TWO: begin x = -x; y = -y; end
            QUAD_THREE: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        res.x = round_sat(x);
        res.y = round_sat(y);
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            3: return IN_W'(32'h8000 + $urandom_range(0, 4) - 2);
            default: return IN_W'($urandom);
        endcase
    endfunction

    initial begin
        pair_t p;
        logic [IN_W-1:0] edges[6] = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff,
                                      16'h8001, 16'h4000};
        foreach (edges[i]) begin
            foreach (edges[j]) begin
                if (i < 4 || j < 4) begin
                    p.u_first = edges[i];
                    p.u_second = edges[j];
                    if (pending_pairs.size() < 25) pending_pairs.push_back(p);
                end
            end
        end
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) begin
                p.u_first = pick_value();
                p.u_second = pick_value();
            end else begin
                p.u_first = IN_W'($urandom);
                p.u_second = IN_W'($urandom);
                if ($urandom_range(0, 3) == 0) p.u_second = p.u_first;
                else if ($urandom_range(0, 3) == 0) p.u_second = 16'hffff - p.u_first;
            end
            pending_pairs.push_back(p);
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // sender
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_points.push_back(map_to_disc({s_u_first, s_u_second}));
                sent <= sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() > 0 && (quiet_span || $urandom_range(0, 99) >= 18)) begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    s_valid <= 1'b1;
                    s_u_first <= p.u_first;
                    s_u_second <= p.u_second;
                end else begin
                    s_valid <= 1'b0;
                    if (pending_pairs.size() == 0) stimulus_done <= 1'b1;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_span <= (sent >= 300 && sent < 600);
            if (!hold_done && sent >= 800) begin
                hold_count <= hold_count + 1;
                m_ready <= 1'b0;
                if (hold_count == 200) hold_done <= 1'b1;
            end else begin
                m_ready <= quiet_span || ($urandom_range(0, 99) >= 18);
            end
            if (m_valid && m_ready) begin
                received <= received + 1;
                if (expected_points.size() == 0) begin
                    $error("unexpected item: x=%0d y=%0d", m_disc_x, m_disc_y);
                    errors++;
                end else begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (m_disc_x !== e.x) begin
                        $error("disc_x: expected %0d, got %0d", e.x, m_disc_x);
                        errors++;
                    end
                    if (m_disc_y !== e.y) begin
                        $error("disc_y: expected %0d, got %0d", e.y, m_disc_y);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d items in, %0d out", sent, received);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && !s_valid && expected_points.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (expected_points.size() != 0) errors++;
        $display("Ran %0d pairs through the disc mapping, %0d points checked,", sent,
                 received);
        $display("covering all four regions, the origin, edges and a long output stall.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
src/cdm_pkg.sv
src/concentric_disc_mapping_top.sv
tb/sv/testbench.sv
